FILE: rtl/bscl_pkg.sv
`default_nettype none

package bscl_pkg;

  // sizes
  localparam int MaxEntriesDef = 64;
  localparam int CAP_W         = 7;
  localparam int ID_W          = 32;
  localparam int DIST_W        = 32;
  localparam int ACT_W         = 2;
  localparam int STAT_W        = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TAKE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_INSERTED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP        = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_BETTER = 3'd2;
  localparam logic [STAT_W-1:0] STAT_TAKEN      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd4;
  localparam logic [STAT_W-1:0] STAT_CLEARED    = 3'd5;

  // control broadcast to every cell
  typedef struct packed {
    logic eval_en;   // latch compare flags against the arriving request
    logic ins_en;    // shift toward the tail and drop the new entry in
    logic take_en;   // mark the selected cell expanded
  } bscl_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bscl_cell.sv
`default_nettype none

module bscl_cell import bscl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bscl_ctl_t         ctl_i,
  input  wire logic              valid_i,
  input  wire logic [ID_W-1:0]   cmp_id_i,
  input  wire logic [DIST_W-1:0] cmp_dist_i,
  input  wire logic [ID_W-1:0]   new_id_i,
  input  wire logic [DIST_W-1:0] new_dist_i,
  input  wire logic [ID_W-1:0]   prev_id_i,
  input  wire logic [DIST_W-1:0] prev_dist_i,
  input  wire logic              prev_exp_i,
  input  wire logic              prev_before_i,
  input  wire logic              first_i,
  output logic [ID_W-1:0]        id_o,
  output logic [DIST_W-1:0]      dist_o,
  output logic                   exp_o,
  output logic                   before_o,
  output logic                   match_o
);

  logic [ID_W-1:0]   id_q;
  logic [DIST_W-1:0] dist_q;
  logic              exp_q;
  logic              before_q, before_d;
  logic              match_q, match_d;
  logic              shift_in;

  // compare held entry with the arriving candidate
  always_comb begin
    before_d = valid_i && ((dist_q < cmp_dist_i) ||
                           ((dist_q == cmp_dist_i) && (id_q < cmp_id_i)));
    match_d  = valid_i && (id_q == cmp_id_i);
  end

  // this cell changes on insert unless it sorts before the newcomer
  assign shift_in = ctl_i.ins_en && !before_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= 1'b0;
      match_q  <= 1'b0;
    end else if (ctl_i.eval_en) begin
      before_q <= before_d;
      match_q  <= match_d;
    end
  end

  // entry payload: take the newcomer at the insert point, else the neighbor
  always_ff @(posedge clk_i) begin
    if (shift_in) begin
      if (prev_before_i) begin
        id_q   <= new_id_i;
        dist_q <= new_dist_i;
      end else begin
        id_q   <= prev_id_i;
        dist_q <= prev_dist_i;
      end
    end
  end

  // expanded mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 1'b0;
    end else if (shift_in) begin
      exp_q <= prev_before_i ? 1'b0 : prev_exp_i;
    end else if (ctl_i.take_en && first_i) begin
      exp_q <= 1'b1;
    end
  end

  assign id_o     = id_q;
  assign dist_o   = dist_q;
  assign exp_o    = exp_q;
  assign before_o = before_q;
  assign match_o  = match_q;

endmodule

`default_nettype wire

FILE: rtl/bounded_sorted_candidate_list.sv
`default_nettype none

// Sorted candidate list for beam search. Up to MAX_ENTRIES (id, distance)
// entries sit in a row of cells ordered by distance, then id; each cell
// compares itself with an arriving candidate and takes its neighbor's entry
// when an insert opens a slot. Every request (insert, take, clear) is
// handled in order: the accept edge latches the per-cell compare flags and
// the request, then busy_q applies the update and loads the result register,
// so no new request is accepted while one is in flight or a stalled result
// is held. The take path finds the closest unexpanded entry with a
// lowest-set-bit pick across the cells. The capacity register (cfg_wdata_i,
// 0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES) must only be
// written while no request is in flight; lowering it drops the worst
// entries at once.

module bounded_sorted_candidate_list import bscl_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntriesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [ID_W-1:0]   item_id_i,
  input  wire logic [DIST_W-1:0] item_dist_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [ID_W-1:0]        taken_id_o,
  output logic [DIST_W-1:0]      taken_dist_o,
  output logic                   any_unexpanded_o,
  output logic [CAP_W-1:0]       entry_count_o
);

  localparam int N     = MAX_ENTRIES;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // capacity clamp to 1..MAX_ENTRIES
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
    logic [EXT_W-1:0] vx;
    vx = EXT_W'(v);
    if (v == '0) return CNT_W'(1);
    else if (vx > EXT_W'(MAX_ENTRIES)) return CNT_W'(MAX_ENTRIES);
    else return CNT_W'(vx);
  endfunction

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cap_eff, cap_new;
  logic              busy_q;
  logic              in_accept;

  logic [ACT_W-1:0]  req_act_q;
  logic [ID_W-1:0]   req_id_q;
  logic [DIST_W-1:0] req_dist_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ID_W-1:0]   taken_id_q, taken_id_d;
  logic [DIST_W-1:0] taken_dist_q, taken_dist_d;
  logic              any_q, any_d;
  logic [CAP_W-1:0]  ecount_q;

  bscl_ctl_t         ctl;
  logic [N-1:0]      valid_vec, exp_vec, before_vec, match_vec;
  logic [N-1:0]      unexp_vec, first_vec;
  logic [ID_W-1:0]   cell_id   [N];
  logic [DIST_W-1:0] cell_dist [N];

  logic              dup, full, not_better, ins_ok, take_ok, has_unexp;
  logic [ID_W-1:0]   sel_id;
  logic [DIST_W-1:0] sel_dist;

  // request handshake: one request in flight, result register must be free
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_act_q  <= action_i;
      req_id_q   <= item_id_i;
      req_dist_q <= item_dist_i;
    end
  end

  // cell row
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [ID_W-1:0]   prev_id;
    logic [DIST_W-1:0] prev_dist;
    logic              prev_exp;
    logic              prev_before;

    if (k == 0) begin : g_head
      assign prev_id     = '0;
      assign prev_dist   = '0;
      assign prev_exp    = 1'b0;
      assign prev_before = 1'b1;
    end else begin : g_body
      assign prev_id     = cell_id[k-1];
      assign prev_dist   = cell_dist[k-1];
      assign prev_exp    = exp_vec[k-1];
      assign prev_before = before_vec[k-1];
    end

    assign valid_vec[k] = CNT_W'(k) < count_q;

    bscl_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .valid_i       (valid_vec[k]),
      .cmp_id_i      (item_id_i),
      .cmp_dist_i    (item_dist_i),
      .new_id_i      (req_id_q),
      .new_dist_i    (req_dist_q),
      .prev_id_i     (prev_id),
      .prev_dist_i   (prev_dist),
      .prev_exp_i    (prev_exp),
      .prev_before_i (prev_before),
      .first_i       (first_vec[k]),
      .id_o          (cell_id[k]),
      .dist_o        (cell_dist[k]),
      .exp_o         (exp_vec[k]),
      .before_o      (before_vec[k]),
      .match_o       (match_vec[k])
    );
  end

  // decisions from the latched flags
  assign cap_eff    = eff_cap(cap_q);
  assign cap_new    = eff_cap(cfg_wdata_i);
  assign unexp_vec  = valid_vec & ~exp_vec;
  assign first_vec  = unexp_vec & ((~unexp_vec) + N'(1));
  assign has_unexp  = |unexp_vec;
  assign dup        = |match_vec;
  assign full       = count_q >= cap_eff;
  assign not_better = full && (before_vec == valid_vec);
  assign ins_ok     = busy_q && (req_act_q == ACT_INSERT) && !dup && !not_better;
  assign take_ok    = busy_q && (req_act_q == ACT_TAKE) && has_unexp;

  assign ctl.eval_en = in_accept;
  assign ctl.ins_en  = ins_ok;
  assign ctl.take_en = take_ok;

  // pick the closest unexpanded entry
  always_comb begin
    sel_id   = '0;
    sel_dist = '0;
    for (int k = 0; k < N; k++) begin
      sel_id   = sel_id   | (cell_id[k]   & {ID_W{first_vec[k]}});
      sel_dist = sel_dist | (cell_dist[k] & {DIST_W{first_vec[k]}});
    end
  end

  // result and new count
  always_comb begin
    status_d     = STAT_DUP;
    taken_id_d   = '0;
    taken_dist_d = '0;
    any_d        = has_unexp;
    count_d      = count_q;
    case (req_act_q)
      ACT_INSERT: begin
        if (dup) begin
          status_d = STAT_DUP;
        end else if (not_better) begin
          status_d = STAT_NOT_BETTER;
        end else begin
          status_d = STAT_INSERTED;
          any_d    = 1'b1;
          if (!full) count_d = count_q + CNT_W'(1);
        end
      end
      ACT_TAKE: begin
        if (has_unexp) begin
          status_d     = STAT_TAKEN;
          taken_id_d   = sel_id;
          taken_dist_d = sel_dist;
          any_d        = |(unexp_vec & ~first_vec);
        end else begin
          status_d = STAT_EMPTY;
        end
      end
      ACT_CLEAR: begin
        status_d = STAT_CLEARED;
        any_d    = 1'b0;
        count_d  = '0;
      end
      default: begin
        status_d = STAT_DUP;
      end
    endcase
  end

  // capacity register and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
      if (count_q > cap_new) count_q <= cap_new;
    end else if (busy_q) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (busy_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q     <= status_d;
      taken_id_q   <= taken_id_d;
      taken_dist_q <= taken_dist_d;
      any_q        <= any_d;
      ecount_q     <= CAP_W'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign taken_id_o       = taken_id_q;
  assign taken_dist_o     = taken_dist_q;
  assign any_unexpanded_o = any_q;
  assign entry_count_o    = ecount_q;

endmodule

`default_nettype wire

FILE: rtl/bscl_chk.sv
`default_nettype none

module bscl_chk import bscl_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [STAT_W-1:0] status_o,
  input wire logic [ID_W-1:0]   taken_id_o,
  input wire logic [DIST_W-1:0] taken_dist_o,
  input wire logic              any_unexpanded_o,
  input wire logic [CAP_W-1:0]  entry_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(taken_id_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // only a take returns an entry
  a_taken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_TAKEN) |-> (taken_id_o == '0) && (taken_dist_o == '0))
    else $error("taken fields set without a take");

  // a fresh insert is always unexpanded
  a_ins_unexp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_INSERTED) |-> any_unexpanded_o && (entry_count_o != '0))
    else $error("insert left nothing unexpanded");

  // clear leaves an empty list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_CLEARED) |-> !any_unexpanded_o && (entry_count_o == '0))
    else $error("clear left entries");

  // failed take means nothing was left to take
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_EMPTY) |-> !any_unexpanded_o)
    else $error("take failed with unexpanded entries");

endmodule

bind bounded_sorted_candidate_list bscl_chk u_bscl_chk (.*);

`default_nettype wire
